@@ rtl/jsu_pkg.sv @@
// Shared types, character codes and helper functions for the JSON string decoder.
`timescale 1ns / 1ps

package jsu_pkg;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       source_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       final_item;
  } out_beat_t;

  // One entry of the front-to-back queue: either one to four decoded bytes
  // or a single end-of-string beat.
  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0]      err;
    logic [1:0]      last;     // index of the last byte to send
    logic [3:0][7:0] bytes;    // bytes[0] goes out first
  } cmd_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_NO_OPEN       = 4'd1;
  localparam logic [3:0] ERR_NO_CLOSE      = 4'd2;
  localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd3;
  localparam logic [3:0] ERR_SHORT_UNICODE = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX       = 4'd5;
  localparam logic [3:0] ERR_SHORT_PAIR    = 4'd6;
  localparam logic [3:0] ERR_PAIR_NO_BSL   = 4'd7;
  localparam logic [3:0] ERR_PAIR_NO_U     = 4'd8;
  localparam logic [3:0] ERR_BAD_LOW       = 4'd9;
  localparam logic [3:0] ERR_UNFINISHED    = 4'd10;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [20:0] RUNE_MAX  = 21'h10FFFF;
  localparam logic [20:0] RUNE_REPL = 21'h00FFFD;

  // {valid, value} of one hex digit character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {valid, value} of four hex digits, most significant first
  function automatic logic [16:0] hex4(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3);
    logic [4:0] d0, d1, d2, d3;
    d0 = hex_digit(c0);
    d1 = hex_digit(c1);
    d2 = hex_digit(c2);
    d3 = hex_digit(c3);
    return {d0[4] & d1[4] & d2[4] & d3[4], d0[3:0], d1[3:0], d2[3:0], d3[3:0]};
  endfunction

endpackage

@@ rtl/jsu_front.sv @@
// Front end: literal layer and escape decoder, one source byte per cycle while the queue is not full.
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_beat_t item,
  input  logic     q_full,
  output logic     cmd_valid,
  output cmd_t     cmd
);

  localparam logic [2:0] PH_WAIT  = 3'd0;
  localparam logic [2:0] PH_PLAIN = 3'd1;
  localparam logic [2:0] PH_ESC   = 3'd2;
  localparam logic [2:0] PH_HEX   = 3'd3;
  localparam logic [2:0] PH_PAIR  = 3'd4;

  logic [2:0]  phase, phase_next;
  logic        esc, esc_next;
  logic [2:0]  lcnt, lcnt_next;
  logic [15:0] hs, hs_next;
  logic [3:0]  herr, herr_next;
  logic [7:0]  lb [6];
  logic        lb_we;
  logic        produce;
  logic        accept;
  logic [16:0] hx;
  logic [7:0]  b;

  // UTF-8 encoding of a rune into a queue entry
  function automatic cmd_t encode(input logic [20:0] rune_in);
    cmd_t c;
    logic [20:0] r;
    r = (rune_in > RUNE_MAX) ? RUNE_REPL : rune_in;
    c = '0;
    c.kind = KIND_BYTE;
    c.err  = ERR_NONE;
    if (r < 21'h80) begin
      c.last = 2'd0;
      c.bytes[0] = r[7:0];
    end else if (r < 21'h800) begin
      c.last = 2'd1;
      c.bytes[0] = {3'b110, r[10:6]};
      c.bytes[1] = {2'b10, r[5:0]};
    end else if (r < 21'h10000) begin
      c.last = 2'd2;
      c.bytes[0] = {4'b1110, r[15:12]};
      c.bytes[1] = {2'b10, r[11:6]};
      c.bytes[2] = {2'b10, r[5:0]};
    end else begin
      c.last = 2'd3;
      c.bytes[0] = {5'b11110, r[20:18]};
      c.bytes[1] = {2'b10, r[17:12]};
      c.bytes[2] = {2'b10, r[11:6]};
      c.bytes[3] = {2'b10, r[5:0]};
    end
    return c;
  endfunction

  function automatic cmd_t one_byte(input logic [7:0] v);
    cmd_t c;
    c = '0;
    c.kind = KIND_BYTE;
    c.bytes[0] = v;
    return c;
  endfunction

  function automatic cmd_t finish(input logic [3:0] e);
    cmd_t c;
    c = '0;
    c.kind = (e == ERR_NONE) ? KIND_OK : KIND_FAIL;
    c.err  = e;
    return c;
  endfunction

  assign b      = item.source_byte;
  assign accept = push && !q_full;

  always_comb begin
    phase_next = phase;
    esc_next   = esc;
    lcnt_next  = lcnt;
    hs_next    = hs;
    herr_next  = herr;
    lb_we      = 1'b0;
    produce    = 1'b0;
    cmd        = '0;
    hx         = '0;
    if (phase == PH_WAIT) begin
      if (b != CH_QUOTE) begin
        produce = 1'b1;
        cmd     = finish(ERR_NO_OPEN);
      end else if (item.source_end) begin
        produce = 1'b1;
        cmd     = finish(ERR_NO_CLOSE);
      end else begin
        phase_next = PH_PLAIN;
        esc_next   = 1'b0;
        lcnt_next  = 3'd0;
        hs_next    = 16'd0;
        herr_next  = ERR_NONE;
      end
    end else if (!esc && b == CH_QUOTE) begin
      produce = 1'b1;
      if (herr != ERR_NONE) begin
        cmd = finish(herr);
      end else if (phase == PH_HEX) begin
        cmd = finish(ERR_SHORT_UNICODE);
      end else if (phase == PH_PAIR) begin
        cmd = finish(ERR_SHORT_PAIR);
      end else if (phase == PH_ESC) begin
        cmd = finish(ERR_UNFINISHED);
      end else begin
        cmd = finish(ERR_NONE);
      end
      phase_next = PH_WAIT;
      esc_next   = 1'b0;
      lcnt_next  = 3'd0;
      hs_next    = 16'd0;
      herr_next  = ERR_NONE;
    end else if (item.source_end) begin
      produce    = 1'b1;
      cmd        = finish((!esc && b == CH_BSL) ? ERR_UNFINISHED : ERR_NO_CLOSE);
      phase_next = PH_WAIT;
      esc_next   = 1'b0;
      lcnt_next  = 3'd0;
      hs_next    = 16'd0;
      herr_next  = ERR_NONE;
    end else begin
      esc_next = esc ? 1'b0 : (b == CH_BSL);
      if (herr == ERR_NONE) begin
        case (phase)
          PH_ESC: begin
            phase_next = PH_PLAIN;
            case (b)
              CH_B: begin produce = 1'b1; cmd = one_byte(8'h08); end
              CH_F: begin produce = 1'b1; cmd = one_byte(8'h0C); end
              CH_N: begin produce = 1'b1; cmd = one_byte(8'h0A); end
              CH_R: begin produce = 1'b1; cmd = one_byte(8'h0D); end
              CH_T: begin produce = 1'b1; cmd = one_byte(8'h09); end
              CH_SLASH, CH_BSL, CH_QUOTE: begin
                produce = 1'b1;
                cmd = one_byte(b);
              end
              CH_U: begin
                phase_next = PH_HEX;
                lcnt_next  = 3'd0;
              end
              default: herr_next = ERR_BAD_ESCAPE;
            endcase
          end
          PH_HEX: begin
            if (lcnt < 3'd3) begin
              lb_we     = 1'b1;
              lcnt_next = lcnt + 3'd1;
            end else begin
              lcnt_next = 3'd0;
              hx = hex4(lb[0], lb[1], lb[2], b);
              if (!hx[16]) begin
                herr_next  = ERR_BAD_HEX;
                phase_next = PH_PLAIN;
              end else if (hx[15:0] >= 16'hD800 && hx[15:0] <= 16'hDBFF) begin
                hs_next    = hx[15:0];
                phase_next = PH_PAIR;
              end else begin
                phase_next = PH_PLAIN;
                produce    = 1'b1;
                cmd        = encode({5'd0, hx[15:0]});
              end
            end
          end
          PH_PAIR: begin
            if (lcnt < 3'd5) begin
              lb_we     = 1'b1;
              lcnt_next = lcnt + 3'd1;
            end else begin
              lcnt_next  = 3'd0;
              phase_next = PH_PLAIN;
              hx = hex4(lb[2], lb[3], lb[4], b);
              if (lb[0] != CH_BSL) begin
                herr_next = ERR_PAIR_NO_BSL;
              end else if (lb[1] != CH_U) begin
                herr_next = ERR_PAIR_NO_U;
              end else if (!hx[16]) begin
                herr_next = ERR_BAD_HEX;
              end else if (hx[15:0] < 16'hDC00 || hx[15:0] > 16'hDFFF) begin
                herr_next = ERR_BAD_LOW;
              end else begin
                // 0x10000 + ((hi - 0xD800) << 10 | (lo - 0xDC00))
                produce = 1'b1;
                cmd     = encode(21'h10000 + {1'b0, hs[9:0], hx[9:0]});
              end
            end
          end
          default: begin
            if (b == CH_BSL) begin
              phase_next = PH_ESC;
            end else begin
              phase_next = PH_PLAIN;
              produce    = 1'b1;
              cmd        = one_byte(b);
            end
          end
        endcase
      end
    end
  end

  assign cmd_valid = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      esc   <= 1'b0;
      lcnt  <= 3'd0;
      hs    <= 16'd0;
      herr  <= ERR_NONE;
    end else if (accept) begin
      phase <= phase_next;
      esc   <= esc_next;
      lcnt  <= lcnt_next;
      hs    <= hs_next;
      herr  <= herr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && lb_we) begin
      lb[lcnt] <= b;
    end
  end

endmodule

@@ rtl/jsu_queue.sv @@
// Small queue of decoded commands between front and back end.
`timescale 1ns / 1ps

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd,
  output logic valid,
  output cmd_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

@@ rtl/jsu_back.sv @@
// Back end: expands queued commands into result beats, one per cycle while pop is high.
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_data,
  output logic      q_rd,
  output logic      empty,
  input  logic      pop,
  output out_beat_t result
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       advance, done, load;

  assign advance = pop && cur_valid;
  assign done    = advance && (idx == cur.last);
  assign load    = (!cur_valid || done) && q_valid;
  assign q_rd    = load;
  assign empty   = !cur_valid;

  assign result.out_byte   = cur.bytes[idx];
  assign result.kind       = cur.kind;
  assign result.error_code = cur.err;
  assign result.final_item = (cur.kind != KIND_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (advance) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// Top level of the streaming JSON string literal decoder.
//
// Source text goes in one byte a beat (push/full), starting at the opening quote;
// decoded UTF-8 bytes and one end-of-string beat come out in order (empty/pop).
// The front end takes one source byte per cycle while full is low: it tracks
// backslash pairing to find the closing quote, decodes simple escapes and \u
// escapes (with a following low surrogate), and holds the first decode error until
// the string closes. Each byte yields at most one queue entry, holding either one
// to four UTF-8 bytes or a final ok/fail beat. The back end sends one result beat
// per cycle while pop is high, so each UTF-8 byte of an expanded \u escape takes
// its own beat. The QUEUE_DEPTH-entry queue between the two absorbs those bursts;
// full rises only when it fills, i.e. when output expands faster than pop drains
// it. An accepted byte's entry is registered in the queue, then in the back end's
// current command, which drives its first result beat. Errors are reported only on
// the final beat; after a decode error no further decoded bytes appear for that
// string. After any final beat the block waits for a new opening quote.
`timescale 1ns / 1ps

module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_beat_t  item,
  output logic      empty,
  input  logic      pop,
  output out_beat_t result
);

  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_data;
  logic q_rd;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .q_full    (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // decoupling queue; full backpressures the source directly
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_valid),
    .wr_data (cmd),
    .full    (full),
    .rd      (q_rd),
    .valid   (q_valid),
    .rd_data (q_data)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ tb/json_string_unescape_utf8_checker.sv @@
// Checker for the JSON string decoder: predicts result beats and compares them.
`timescale 1ns / 1ps

module jsu_decode_checker
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_beat_t  item,
  input  logic      empty,
  input  logic      pop,
  input  out_beat_t result,
  output int        fail_count,
  output int        pending
);

  typedef enum logic [2:0] {ST_IDLE, ST_BODY, ST_ESCAPE, ST_HEX, ST_PAIR} dec_state_t;

  dec_state_t  st;
  logic        in_escape;    // literal layer: previous byte was an unpaired backslash
  logic [7:0]  hold_buf [6];
  int unsigned hold_n;
  logic [15:0] hi_surr;
  logic [3:0]  first_err;
  out_beat_t   decoded_q [$];
  out_beat_t   want;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return -1;
  endfunction

  // four held hex digits from pos on, -1 on any bad digit
  function automatic int hex_word(input int pos);
    int v;
    int d;
    v = 0;
    for (int i = 0; i < 4; i++) begin
      d = hex_nibble(hold_buf[(pos + i) % 6]);
      if (d < 0) return -1;
      v = (v << 4) | d;
    end
    return v;
  endfunction

  task automatic add_beat(input logic [7:0] b, input logic [1:0] k, input logic [3:0] e,
                          input logic f);
    decoded_q.push_back('{out_byte: b, kind: k, error_code: e, final_item: f});
  endtask

  task automatic add_rune(input logic [20:0] r);
    if (r > RUNE_MAX) r = RUNE_REPL;
    if (r < 21'h80) begin
      add_beat(r[7:0], KIND_BYTE, ERR_NONE, 1'b0);
    end else if (r < 21'h800) begin
      add_beat({3'b110, r[10:6]}, KIND_BYTE, ERR_NONE, 1'b0);
      add_beat({2'b10, r[5:0]}, KIND_BYTE, ERR_NONE, 1'b0);
    end else if (r < 21'h10000) begin
      add_beat({4'b1110, r[15:12]}, KIND_BYTE, ERR_NONE, 1'b0);
      add_beat({2'b10, r[11:6]}, KIND_BYTE, ERR_NONE, 1'b0);
      add_beat({2'b10, r[5:0]}, KIND_BYTE, ERR_NONE, 1'b0);
    end else begin
      add_beat({5'b11110, r[20:18]}, KIND_BYTE, ERR_NONE, 1'b0);
      add_beat({2'b10, r[17:12]}, KIND_BYTE, ERR_NONE, 1'b0);
      add_beat({2'b10, r[11:6]}, KIND_BYTE, ERR_NONE, 1'b0);
      add_beat({2'b10, r[5:0]}, KIND_BYTE, ERR_NONE, 1'b0);
    end
  endtask

  task automatic clear_state();
    st        = ST_IDLE;
    in_escape = 1'b0;
    hold_n    = 0;
    hi_surr   = '0;
    first_err = ERR_NONE;
  endtask

  task automatic note_error(input logic [3:0] code);
    first_err = code;
    st        = ST_BODY;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int v;
    case (st)
      ST_ESCAPE: begin
        st = ST_BODY;
        case (b)
          CH_B: add_beat(8'h08, KIND_BYTE, ERR_NONE, 1'b0);
          CH_F: add_beat(8'h0C, KIND_BYTE, ERR_NONE, 1'b0);
          CH_N: add_beat(8'h0A, KIND_BYTE, ERR_NONE, 1'b0);
          CH_R: add_beat(8'h0D, KIND_BYTE, ERR_NONE, 1'b0);
          CH_T: add_beat(8'h09, KIND_BYTE, ERR_NONE, 1'b0);
          CH_SLASH, CH_BSL, CH_QUOTE: add_beat(b, KIND_BYTE, ERR_NONE, 1'b0);
          CH_U: begin
            st     = ST_HEX;
            hold_n = 0;
          end
          default: note_error(ERR_BAD_ESCAPE);
        endcase
      end
      ST_HEX: begin
        hold_buf[hold_n % 6] = b;
        hold_n++;
        if (hold_n == 4) begin
          hold_n = 0;
          v = hex_word(0);
          if (v < 0) begin
            note_error(ERR_BAD_HEX);
          end else if (v >= 'hD800 && v <= 'hDBFF) begin
            hi_surr = v[15:0];
            st      = ST_PAIR;
          end else begin
            st = ST_BODY;
            add_rune(v[20:0]);
          end
        end
      end
      ST_PAIR: begin
        hold_buf[hold_n % 6] = b;
        hold_n++;
        if (hold_n == 6) begin
          hold_n = 0;
          v = hex_word(2);
          if (hold_buf[0] != CH_BSL) note_error(ERR_PAIR_NO_BSL);
          else if (hold_buf[1] != CH_U) note_error(ERR_PAIR_NO_U);
          else if (v < 0) note_error(ERR_BAD_HEX);
          else if (v < 'hDC00 || v > 'hDFFF) note_error(ERR_BAD_LOW);
          else begin
            st = ST_BODY;
            add_rune(21'(21'h10000 + ({5'd0, hi_surr - 16'hD800} << 10)
                         + (v - 'hDC00)));
          end
        end
      end
      default: begin
        if (b == CH_BSL) st = ST_ESCAPE;
        else begin
          st = ST_BODY;
          add_beat(b, KIND_BYTE, ERR_NONE, 1'b0);
        end
      end
    endcase
  endtask

  task automatic predict_beat(input in_beat_t x);
    logic [7:0] b;
    logic [3:0] code;
    b = x.source_byte;
    if (st == ST_IDLE) begin
      if (b != CH_QUOTE) add_beat(8'h00, KIND_FAIL, ERR_NO_OPEN, 1'b1);
      else if (x.source_end) add_beat(8'h00, KIND_FAIL, ERR_NO_CLOSE, 1'b1);
      else begin
        clear_state();
        st = ST_BODY;
      end
    end else if (!in_escape && b == CH_QUOTE) begin
      code = first_err;
      if (code == ERR_NONE) begin
        case (st)
          ST_HEX:    code = ERR_SHORT_UNICODE;
          ST_PAIR:   code = ERR_SHORT_PAIR;
          ST_ESCAPE: code = ERR_UNFINISHED;
          default:   code = ERR_NONE;
        endcase
      end
      if (code == ERR_NONE) add_beat(8'h00, KIND_OK, ERR_NONE, 1'b1);
      else add_beat(8'h00, KIND_FAIL, code, 1'b1);
      clear_state();
    end else if (x.source_end) begin
      // literal errors outrank anything held
      add_beat(8'h00, KIND_FAIL,
               (!in_escape && b == CH_BSL) ? ERR_UNFINISHED : ERR_NO_CLOSE, 1'b1);
      clear_state();
    end else begin
      in_escape = in_escape ? 1'b0 : (b == CH_BSL);
      if (first_err == ERR_NONE) decode_byte(b);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      decoded_q.delete();
    end else begin
      if (push && !full) predict_beat(item);
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with nothing expected: out_byte %0h kind %0d error_code %0d",
                 result.out_byte, result.kind, result.error_code);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
            fail_count++;
          end
          if (result.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, result.kind);
            fail_count++;
          end
          if (result.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, result.error_code);
            fail_count++;
          end
          if (result.final_item !== want.final_item) begin
            $error("final_item: expected %0b, got %0b", want.final_item, result.final_item);
            fail_count++;
          end
        end
      end
    end
    pending <= decoded_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the JSON string decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  logic      clk;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  logic      full;
  logic      empty;
  in_beat_t  item = '0;
  out_beat_t result;

  int          fail_count;
  int          pending;
  int unsigned send_idle_pct = 0;  // chance in a hundred that the sender idles a cycle
  int unsigned rx_stall_pct  = 0;  // chance in a hundred that the receiver stalls a cycle
  int unsigned sent_items    = 0;
  int unsigned strings_sent  = 0;
  logic [7:0]  src_text [$];       // source text of the string being built

  json_string_unescape_utf8 dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  jsu_decode_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: one coin per cycle, so stalls can land on any beat of a UTF-8 burst.
  always @(posedge clk) begin
    pop <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // One source byte. Idle cycles go before the beat and carry junk on the item bus,
  // which the block must ignore while push is low. The beat is taken at the first
  // edge where full was low; full is read right after the edge, before it updates.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      item <= '{source_byte: 8'($urandom), source_end: 1'($urandom)};
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{source_byte: b, source_end: last};
    do @(posedge clk); while (full);
    sent_items++;
  endtask

  // Sends src_text. With cut set the source ends at a random byte, which gives
  // the missing closing quote and trailing backslash cases; otherwise the end
  // flag sometimes rides on the closing quote itself.
  task automatic send_text(input bit cut);
    int stop;
    stop = src_text.size() - 1;
    if (cut) stop = $urandom_range(stop);
    for (int i = 0; i <= stop; i++) begin
      send_byte(src_text[i], (i == stop) && (cut || $urandom_range(3) == 0));
    end
    strings_sent++;
  endtask

  // Any byte but a quote or a backslash; low bit flipped keeps the full range busy.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_QUOTE || b == CH_BSL) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;          // '0'..'9'
    if ($urandom_range(1)) return 8'h61 + n - 4'd10;  // 'a'..'f'
    return 8'h41 + n - 4'd10;                 // 'A'..'F'
  endfunction

  function automatic logic [15:0] high_half();
    case ($urandom_range(3))
      0:       return 16'hD800;
      1:       return 16'hDBFF;
      default: return 16'($urandom_range(16'hDBFF, 16'hD800));
    endcase
  endfunction

  function automatic logic [15:0] low_half();
    case ($urandom_range(3))
      0:       return 16'hDC00;
      1:       return 16'hDFFF;
      default: return 16'($urandom_range(16'hDFFF, 16'hDC00));
    endcase
  endfunction

  // A \u code outside the high surrogates, spread over the 1, 2 and 3 byte forms.
  // Lone low surrogates are legal here and pass as plain runes.
  function automatic logic [15:0] bmp_rune();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(16'h007F, 16'h0000));
      1:       return 16'($urandom_range(16'h07FF, 16'h0080));
      2:       return 16'($urandom_range(16'hD7FF, 16'h0800));
      3:       return 16'($urandom_range(16'hFFFF, 16'hE000));
      default: return low_half();
    endcase
  endfunction

  task automatic add_unicode(input logic [15:0] v);
    src_text.push_back(CH_BSL);
    src_text.push_back(CH_U);
    for (int k = 3; k >= 0; k--) src_text.push_back(hex_char(v[k*4 +: 4]));
  endtask

  // Four digits with one bad one; the bad set hugs the edges of the hex ranges.
  task automatic add_bad_hex4();
    int pos;
    logic [7:0] bad;
    pos = $urandom_range(3);
    case ($urandom_range(5))
      0:       bad = 8'h2F;
      1:       bad = 8'h3A;
      2:       bad = 8'h40;
      3:       bad = 8'h47;
      4:       bad = 8'h60;
      default: bad = 8'h67;
    endcase
    for (int k = 0; k < 4; k++) begin
      src_text.push_back((k == pos) ? bad : hex_char(4'($urandom_range(15))));
    end
  endtask

  // One broken element. closes is set where the closing quote must follow at once
  // (escape cut short), so the builder stops adding body there.
  task automatic add_broken(output bit closes);
    logic [7:0] b;
    int n;
    closes = 1'b0;
    case ($urandom_range(7))
      0: begin  // unknown escape letter
        b = 8'($urandom_range(255));
        if (b inside {CH_B, CH_F, CH_N, CH_R, CH_T, CH_SLASH, CH_BSL, CH_QUOTE, CH_U}) b = 8'h78;
        src_text.push_back(CH_BSL);
        src_text.push_back(b);
      end
      1: begin  // bad digit in a plain \u
        src_text.push_back(CH_BSL);
        src_text.push_back(CH_U);
        add_bad_hex4();
      end
      2: begin  // \u cut short by the closing quote
        src_text.push_back(CH_BSL);
        src_text.push_back(CH_U);
        repeat ($urandom_range(3)) src_text.push_back(hex_char(4'($urandom_range(15))));
        closes = 1'b1;
      end
      3: begin  // high surrogate whose low half is cut short; a lone backslash would
                // escape the quote, so that length is skipped
        add_unicode(high_half());
        n = $urandom_range(4);
        if (n > 0) begin
          src_text.push_back(CH_BSL);
          src_text.push_back(CH_U);
          repeat (n - 1) src_text.push_back(hex_char(4'($urandom_range(15))));
        end
        closes = 1'b1;
      end
      4: begin  // high surrogate followed by plain text
        add_unicode(high_half());
        repeat (6) src_text.push_back(plain_byte());
      end
      5: begin  // backslash after the high half, but not \u
        add_unicode(high_half());
        b = 8'($urandom_range(255));
        if (b == CH_U) b = 8'h55;
        src_text.push_back(CH_BSL);
        src_text.push_back(b);
        repeat (4) src_text.push_back(plain_byte());
      end
      6: begin  // second half is not a low surrogate
        add_unicode(high_half());
        add_unicode(16'($urandom_range(16'hFFFF) & ~16'h2000 | (($urandom_range(1)) << 13)
                        ^ 16'h0000));
        if (src_text[src_text.size()-4] inside {8'h44, 8'h64}) begin
          // 'D'/'d' lead digit might land in the low range; force a high one
          src_text[src_text.size()-3] = 8'h38;
        end
      end
      default: begin  // bad digit in the low half
        add_unicode(high_half());
        src_text.push_back(CH_BSL);
        src_text.push_back(CH_U);
        add_bad_hex4();
      end
    endcase
  endtask

  // Mostly well-formed strings with random content; now and then one or two stray
  // bytes ahead of the opening quote, or a broken element.
  task automatic build_string();
    int n;
    int pick;
    bit closes;
    src_text.delete();
    closes = 1'b0;
    if ($urandom_range(9) == 0) repeat ($urandom_range(2, 1)) src_text.push_back(plain_byte());
    src_text.push_back(CH_QUOTE);
    n = $urandom_range(6);
    for (int i = 0; i < n && !closes; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        src_text.push_back(plain_byte());
      end else if (pick < 60) begin
        src_text.push_back(CH_BSL);
        case ($urandom_range(7))
          0:       src_text.push_back(CH_B);
          1:       src_text.push_back(CH_F);
          2:       src_text.push_back(CH_N);
          3:       src_text.push_back(CH_R);
          4:       src_text.push_back(CH_T);
          5:       src_text.push_back(CH_SLASH);
          6:       src_text.push_back(CH_BSL);
          default: src_text.push_back(CH_QUOTE);
        endcase
      end else if (pick < 78) begin
        add_unicode(bmp_rune());
      end else if (pick < 92) begin
        add_unicode(high_half());
        add_unicode(low_half());
      end else begin
        add_broken(closes);
      end
    end
    src_text.push_back(CH_QUOTE);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: a stray byte while waiting, an opening quote that ends the source,
    // the top rune as a surrogate pair, an unknown escape, a trailing backslash and
    // a source that ends inside the body.
    send_byte(8'hFF, 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    src_text = {CH_QUOTE};
    add_unicode(16'hDBFF);
    add_unicode(16'hDFFF);
    src_text.push_back(CH_QUOTE);
    send_text(1'b0);
    src_text = {CH_QUOTE, CH_BSL, 8'h71, CH_QUOTE};  // \q
    send_text(1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_BSL, 1'b1);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(8'h00, 1'b1);

    // Random strings; the idle mode steps every eight strings.
    while (sent_items < 470) begin
      case ((strings_sent / 8) % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 60; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 60; end
        default: begin send_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      build_string();
      send_text($urandom_range(11) == 0);
    end
    push <= 1'b0;
    @(posedge clk);

    // Drain, then a few more cycles to catch any stray beat.
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[json_string_unescape_utf8] OK");
    end else begin
      $display("[json_string_unescape_utf8] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[json_string_unescape_utf8] ERROR");
    $finish;
  end

endmodule

@@ json_string_unescape_utf8.f @@
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_checker.sv
tb/testbench.sv
